// ===== sv/assert_macros.svh =====
// Assertion helpers; compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Implication checked on every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
// Condition that must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ===== sv/pctb_pkg.sv =====
package pctb_pkg;

  // Sizes
  localparam int MAX_TREES       = 16;
  localparam int MAX_DEPTH       = 8;
  localparam int NODE_SLOTS      = 4096;
  localparam int NODE_ADDR_BITS  = $clog2(NODE_SLOTS);
  localparam int IMAGE_ADDR_BITS = 16;
  localparam int IMAGE_WORDS     = 1 << IMAGE_ADDR_BITS;
  localparam int PIXEL_BITS      = 16;

  // Operation codes of an input transaction
  typedef enum logic [1:0] {
    OP_NODE  = 2'd0,
    OP_PIXEL = 2'd1,
    OP_EVAL  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_DEPTH      = 3'd0;
  localparam logic [2:0] CFG_COUNT      = 3'd1;
  localparam logic [2:0] CFG_ROW_PITCH  = 3'd2;
  localparam logic [2:0] CFG_ROW_STRIDE = 3'd3;
  localparam logic [2:0] CFG_COL_STRIDE = 3'd4;

  // Evaluation sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BASE1,
    ST_BASE2,
    ST_NODE_RD,
    ST_ADDR,
    ST_PIX_RD,
    ST_CMP
  } state_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [11:0] node_address;
    logic [7:0]  first_row_offset;
    logic [7:0]  first_col_offset;
    logic [7:0]  second_row_offset;
    logic [7:0]  second_col_offset;
    logic [15:0] pixel_address;
    logic [15:0] pixel_value;
    logic [7:0]  window_row;
    logic [7:0]  window_col;
  } in_item_t;

  typedef struct packed {
    logic [3:0] tree_index;
    logic [7:0] leaf_index;
    logic       last;
  } out_result_t;

  // Image store access for one cycle
  typedef struct packed {
    logic                       we;
    logic [IMAGE_ADDR_BITS-1:0] waddr;
    logic [PIXEL_BITS-1:0]      wdata;
    logic [IMAGE_ADDR_BITS-1:0] raddr_a;
    logic [IMAGE_ADDR_BITS-1:0] raddr_b;
  } img_req_t;

endpackage

// ===== sv/pctb_image_store.sv =====
module pctb_image_store
  import pctb_pkg::*;
(
  input  logic                  clk,
  input  img_req_t              req,
  output logic [PIXEL_BITS-1:0] pix_a,
  output logic [PIXEL_BITS-1:0] pix_b
);

  logic [PIXEL_BITS-1:0] mem [IMAGE_WORDS];
  logic [PIXEL_BITS-1:0] pix_a_r;
  logic [PIXEL_BITS-1:0] pix_b_r;

  // One write port, two registered read ports
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    pix_a_r <= mem[req.raddr_a];
    pix_b_r <= mem[req.raddr_b];
  end

  assign pix_a = pix_a_r;
  assign pix_b = pix_b_r;

endmodule

// ===== sv/pixel_compare_tree_bank.sv =====
// On loads (node or pixel) busy stays low and the next transaction may follow.
// An evaluation holds busy through the base-address states BASE1 and BASE2 and then, for
// each level of each tree, a node read, an address multiply, a pixel read and a compare.
// The result of each tree is strobed on out_valid in the cycle after its last compare.
// Synchronous active-low reset returns the sequencer to idle and the configuration registers
// and output strobe to their reset values; payload registers, node and image stores are not cleared.
`include "assert_macros.svh"

module pixel_compare_tree_bank
  import pctb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_valid,
  output out_result_t out_result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  // Configuration registers
  logic [3:0] depth_r;
  logic [4:0] count_r;
  logic [8:0] row_pitch_r;
  logic [7:0] row_stride_r;
  logic [7:0] col_stride_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r      <= 4'd8;
      count_r      <= 5'd1;
      row_pitch_r  <= 9'd256;
      row_stride_r <= 8'd1;
      col_stride_r <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEPTH:      depth_r      <= cfg_data[3:0];
        CFG_COUNT:      count_r      <= cfg_data[4:0];
        CFG_ROW_PITCH:  row_pitch_r  <= cfg_data;
        CFG_ROW_STRIDE: row_stride_r <= cfg_data[7:0];
        CFG_COL_STRIDE: col_stride_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Saturated depth and count
  logic [3:0] depth_eff;
  logic [4:0] count_eff;
  logic [8:0] per_tree;
  assign depth_eff = (depth_r == 4'd0) ? 4'd1 :
                     (depth_r > 4'(MAX_DEPTH)) ? 4'(MAX_DEPTH) : depth_r;
  assign count_eff = (count_r == 5'd0) ? 5'd1 :
                     (count_r > 5'(MAX_TREES)) ? 5'(MAX_TREES) : count_r;
  assign per_tree  = (9'd1 << depth_eff) - 9'd1;

  // Sequencer and datapath registers
  state_t                     state_r, state_nxt;
  logic [7:0]                 row_r, row_nxt;
  logic [7:0]                 col_r, col_nxt;
  logic [15:0]                rs_r, rs_nxt;
  logic [15:0]                cs_r, cs_nxt;
  logic [IMAGE_ADDR_BITS-1:0] base_r, base_nxt;
  logic [IMAGE_ADDR_BITS-1:0] addr_a_r, addr_a_nxt;
  logic [IMAGE_ADDR_BITS-1:0] addr_b_r, addr_b_nxt;
  logic [NODE_ADDR_BITS-1:0]  tree_base_r, tree_base_nxt;
  logic [8:0]                 heap_r, heap_nxt;
  logic [2:0]                 level_r, level_nxt;
  logic [3:0]                 tree_r, tree_nxt;
  logic                       out_valid_r, out_valid_nxt;
  out_result_t                out_result_r, out_result_nxt;

  logic                      accept;
  logic [NODE_ADDR_BITS-1:0] node_raddr;
  logic [31:0]               node_q_r;
  logic [PIXEL_BITS-1:0]     pix_a, pix_b;
  img_req_t                  img_req;
  logic [8:0]                heap_step;
  logic                      tree_done;
  logic                      last_tree;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  // Node store: written by node loads, read once per level
  logic [31:0] node_mem [NODE_SLOTS];
  assign node_raddr = NODE_ADDR_BITS'(tree_base_r + NODE_ADDR_BITS'(heap_r) -
                                      NODE_ADDR_BITS'(1));

  always_ff @(posedge clk) begin
    if (accept && in_item.op == OP_NODE) begin
      node_mem[in_item.node_address] <= {in_item.second_col_offset,
                                         in_item.second_row_offset,
                                         in_item.first_col_offset,
                                         in_item.first_row_offset};
    end
    node_q_r <= node_mem[node_raddr];
  end

  // Image store: pixel loads write, the walk reads two pixels per level
  assign img_req.we      = accept && (in_item.op == OP_PIXEL);
  assign img_req.waddr   = in_item.pixel_address;
  assign img_req.wdata   = in_item.pixel_value;
  assign img_req.raddr_a = addr_a_r;
  assign img_req.raddr_b = addr_b_r;

  pctb_image_store u_image_store (
    .clk   (clk),
    .req   (img_req),
    .pix_a (pix_a),
    .pix_b (pix_b)
  );

  // Next step of the walk
  assign heap_step = {heap_r[7:0], (pix_a < pix_b)};
  assign tree_done = (level_r == 3'(depth_eff - 4'd1));
  assign last_tree = (({1'b0, tree_r} + 5'd1) == count_eff);

  // Next state and datapath
  always_comb begin
    state_nxt      = state_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    rs_nxt         = rs_r;
    cs_nxt         = cs_r;
    base_nxt       = base_r;
    addr_a_nxt     = addr_a_r;
    addr_b_nxt     = addr_b_r;
    tree_base_nxt  = tree_base_r;
    heap_nxt       = heap_r;
    level_nxt      = level_r;
    tree_nxt       = tree_r;
    out_valid_nxt  = 1'b0;
    out_result_nxt = out_result_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_item.op == OP_EVAL) begin
          row_nxt   = in_item.window_row;
          col_nxt   = in_item.window_col;
          state_nxt = ST_BASE1;
        end
      end
      ST_BASE1: begin
        rs_nxt        = 16'(row_r * row_stride_r);
        cs_nxt        = 16'(col_r * col_stride_r);
        tree_base_nxt = '0;
        heap_nxt      = 9'd1;
        level_nxt     = '0;
        tree_nxt      = '0;
        state_nxt     = ST_BASE2;
      end
      ST_BASE2: begin
        base_nxt  = IMAGE_ADDR_BITS'(rs_r * row_pitch_r) + IMAGE_ADDR_BITS'(cs_r);
        state_nxt = ST_NODE_RD;
      end
      ST_NODE_RD: begin
        state_nxt = ST_ADDR;
      end
      ST_ADDR: begin
        addr_a_nxt = base_r + IMAGE_ADDR_BITS'(node_q_r[7:0] * row_pitch_r) +
                     IMAGE_ADDR_BITS'(node_q_r[15:8]);
        addr_b_nxt = base_r + IMAGE_ADDR_BITS'(node_q_r[23:16] * row_pitch_r) +
                     IMAGE_ADDR_BITS'(node_q_r[31:24]);
        state_nxt  = ST_PIX_RD;
      end
      ST_PIX_RD: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        heap_nxt  = heap_step;
        level_nxt = level_r + 3'd1;
        state_nxt = ST_NODE_RD;
        if (tree_done) begin
          out_valid_nxt             = 1'b1;
          out_result_nxt.tree_index = tree_r;
          out_result_nxt.leaf_index = 8'(heap_step - (9'd1 << depth_eff));
          out_result_nxt.last       = last_tree;
          heap_nxt                  = 9'd1;
          level_nxt                 = '0;
          tree_nxt                  = tree_r + 4'd1;
          tree_base_nxt             = tree_base_r + NODE_ADDR_BITS'(per_tree);
          if (last_tree) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State register and output strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    row_r        <= row_nxt;
    col_r        <= col_nxt;
    rs_r         <= rs_nxt;
    cs_r         <= cs_nxt;
    base_r       <= base_nxt;
    addr_a_r     <= addr_a_nxt;
    addr_b_r     <= addr_b_nxt;
    tree_base_r  <= tree_base_nxt;
    heap_r       <= heap_nxt;
    level_r      <= level_nxt;
    tree_r       <= tree_nxt;
    out_result_r <= out_result_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  // Checks
  `ASSERT_CLK(a_eval_goes_busy, clk, rst_n, (accept && in_item.op == OP_EVAL) |=> busy)
  `ASSERT_CLK(a_result_from_walk, clk, rst_n, out_valid |-> $past(state_r == ST_CMP))
  `ASSERT_CLK(a_last_ends_eval, clk, rst_n, (out_valid && out_result.last) |-> !busy)
  `ASSERT_NEVER(a_leaf_in_range, clk, rst_n,
    out_valid && ((9'(out_result.leaf_index) >> depth_eff) != 9'd0))

endmodule

// ===== verif/tb_pixel_compare_tree_bank.sv =====
`timescale 1ns / 1ps

module tb_pixel_compare_tree_bank
  import pctb_pkg::*;
();

  // Register index that maps to nothing; writes to it must leave the block unchanged
  localparam logic [2:0] CFG_SPARE = 3'd7;
  localparam int ITEM_TARGET = 460;
  localparam int PHASES = 8;

  // Shadow copy of the tree bank: stores, registers and the leaf results still owed
  class leaf_tracker;
    bit [31:0] nodes [NODE_SLOTS];
    bit node_set [NODE_SLOTS];
    bit [15:0] pixels [IMAGE_WORDS];
    bit pixel_set [IMAGE_WORDS];
    bit [3:0] depth_reg;
    bit [4:0] count_reg;
    bit [8:0] pitch_reg;
    bit [7:0] rstride_reg;
    bit [7:0] cstride_reg;
    out_result_t leaves_due[$];
    int errors;
    int leaves_seen;
    int evals_seen;
    int items_seen;

    function new();
      depth_reg = 4'd8;
      count_reg = 5'd1;
      pitch_reg = 9'd256;
      rstride_reg = 8'd1;
      cstride_reg = 8'd1;
    endfunction

    // Saturated tree shape actually used by an evaluation
    function void shape(output int unsigned d, output int unsigned c);
      d = 32'(depth_reg);
      c = 32'(count_reg);
      if (d < 1) d = 1;
      if (d > MAX_DEPTH) d = MAX_DEPTH;
      if (c < 1) c = 1;
      if (c > MAX_TREES) c = MAX_TREES;
    endfunction

    function int unsigned base_of(bit [7:0] row, bit [7:0] col);
      int unsigned r;
      int unsigned c;
      r = 32'(row);
      c = 32'(col);
      return (r * rstride_reg * pitch_reg + c * cstride_reg) & (IMAGE_WORDS - 1);
    endfunction

    function int unsigned pix_addr(int unsigned base, bit [7:0] r, bit [7:0] c);
      int unsigned ro;
      int unsigned co;
      ro = 32'(r);
      co = 32'(c);
      return (base + ro * pitch_reg + co) & (IMAGE_WORDS - 1);
    endfunction

    // Walk one tree; stops at the first entry never written and reports where it is
    function bit walk(int unsigned t, int unsigned base, int unsigned d,
                      output int unsigned leaf, output bit gap_is_node,
                      output int unsigned gap_addr);
      int unsigned heap;
      int unsigned slot;
      int unsigned a1;
      int unsigned a2;
      bit [31:0] nd;
      heap = 1;
      for (int unsigned lvl = 0; lvl < d; lvl++) begin
        slot = (t * ((1 << d) - 1) + heap - 1) % NODE_SLOTS;
        if (!node_set[slot]) begin
          gap_is_node = 1'b1;
          gap_addr = slot;
          return 1'b0;
        end
        nd = nodes[slot];
        a1 = pix_addr(base, nd[7:0], nd[15:8]);
        a2 = pix_addr(base, nd[23:16], nd[31:24]);
        gap_is_node = 1'b0;
        if (!pixel_set[a1]) begin
          gap_addr = a1;
          return 1'b0;
        end
        if (!pixel_set[a2]) begin
          gap_addr = a2;
          return 1'b0;
        end
        heap = 2 * heap + ((pixels[a1] < pixels[a2]) ? 1 : 0);
      end
      leaf = (heap - (1 << d)) & 8'hFF;
      return 1'b1;
    endfunction

    // First entry an evaluation at this window would read before it is written
    function bit find_gap(bit [7:0] row, bit [7:0] col, output bit is_node,
                          output int unsigned addr);
      int unsigned d;
      int unsigned c;
      int unsigned base;
      int unsigned leaf;
      shape(d, c);
      base = base_of(row, col);
      for (int unsigned t = 0; t < c; t++) begin
        if (!walk(t, base, d, leaf, is_node, addr)) return 1'b1;
      end
      return 1'b0;
    endfunction

    // Accepted input transaction: update stores or queue the leaf of every tree
    function void take_item(in_item_t it);
      int unsigned d;
      int unsigned c;
      int unsigned base;
      int unsigned leaf;
      bit gap_node;
      int unsigned gap_addr;
      out_result_t r;
      case (op_t'(it.op))
        OP_NODE: begin
          nodes[it.node_address] = {it.second_col_offset, it.second_row_offset,
                                    it.first_col_offset, it.first_row_offset};
          node_set[it.node_address] = 1'b1;
          items_seen++;
        end
        OP_PIXEL: begin
          pixels[it.pixel_address] = it.pixel_value;
          pixel_set[it.pixel_address] = 1'b1;
          items_seen++;
        end
        OP_EVAL: begin
          shape(d, c);
          base = base_of(it.window_row, it.window_col);
          for (int unsigned t = 0; t < c; t++) begin
            if (!walk(t, base, d, leaf, gap_node, gap_addr)) begin
              errors++;
              $error("evaluation reads unwritten entry %0d", gap_addr);
            end
            r.tree_index = t[3:0];
            r.leaf_index = leaf[7:0];
            r.last = (t + 1 == c);
            leaves_due.push_back(r);
          end
          evals_seen++;
          items_seen++;
        end
        default: ;
      endcase
    endfunction

    function void take_cfg(bit [2:0] idx, bit [8:0] data);
      case (idx)
        CFG_DEPTH: depth_reg = data[3:0];
        CFG_COUNT: count_reg = data[4:0];
        CFG_ROW_PITCH: pitch_reg = data;
        CFG_ROW_STRIDE: rstride_reg = data[7:0];
        CFG_COL_STRIDE: cstride_reg = data[7:0];
        default: ;
      endcase
    endfunction

    // Compare one strobed result against the oldest leaf still owed
    function void check_leaf(out_result_t got);
      out_result_t want;
      if (leaves_due.size() == 0) begin
        errors++;
        $error("unexpected result: tree_index %0d leaf_index %0d last %0d",
               got.tree_index, got.leaf_index, got.last);
        return;
      end
      want = leaves_due.pop_front();
      leaves_seen++;
      if (got.tree_index !== want.tree_index) begin
        errors++;
        $error("tree_index: expected %0d, actual %0d", want.tree_index, got.tree_index);
      end
      if (got.leaf_index !== want.leaf_index) begin
        errors++;
        $error("leaf_index: expected %0d, actual %0d", want.leaf_index, got.leaf_index);
      end
      if (got.last !== want.last) begin
        errors++;
        $error("last: expected %0d, actual %0d", want.last, got.last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_valid;
  out_result_t out_result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [8:0] cfg_data = '0;

  leaf_tracker board = new();
  bit gaps_on = 1'b1;
  bit [15:0] recent_windows[$];
  int settings_used;

  pixel_compare_tree_bank uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_result(out_result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_leaf(out_result);
  end

  // Present one transaction and hold it until the block takes it
  task automatic send(in_item_t it);
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    board.take_item(it);
  endtask

  task automatic hold_off(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Random idle burst between transactions
  task automatic pace();
    if (gaps_on && $urandom_range(99) < 20) hold_off($urandom_range(18, 1));
  endtask

  // Stop sending until every owed result is in and the sequencer has wound down
  task automatic settle();
    start <= 1'b0;
    while (board.leaves_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(bit [2:0] idx, bit [8:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    board.take_cfg(idx, data);
  endtask

  task automatic configure(bit [8:0] depth_w, bit [8:0] count_w, bit [8:0] pitch_w,
                           bit [8:0] rstride_w, bit [8:0] cstride_w);
    settle();
    write_reg(CFG_DEPTH, depth_w);
    write_reg(CFG_COUNT, count_w);
    write_reg(CFG_ROW_PITCH, pitch_w);
    write_reg(CFG_ROW_STRIDE, rstride_w);
    write_reg(CFG_COL_STRIDE, cstride_w);
    write_reg(CFG_SPARE, 9'($urandom_range(511)));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic in_item_t random_item();
    bit [95:0] r;
    in_item_t it;
    r = {$urandom(), $urandom(), $urandom()};
    it = r[$bits(in_item_t)-1:0];
    // bias intensities so ties and extremes show up in compares
    case ($urandom_range(3))
      0: it.pixel_value = 16'($urandom_range(3));
      1: it.pixel_value = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: ;
    endcase
    return it;
  endfunction

  task automatic send_op(op_t op);
    in_item_t it;
    it = random_item();
    it.op = op;
    send(it);
    pace();
  endtask

  // Load every node and pixel the walk at this window will touch and that is still blank
  task automatic prepare_window(bit [7:0] row, bit [7:0] col);
    bit is_node;
    int unsigned addr;
    in_item_t it;
    while (board.find_gap(row, col, is_node, addr)) begin
      it = random_item();
      if (is_node) begin
        it.op = OP_NODE;
        it.node_address = 12'(addr);
        // mostly tight offsets so nearby windows share pixels
        if ($urandom_range(3) != 0) begin
          it.first_row_offset = 8'($urandom_range(3));
          it.first_col_offset = 8'($urandom_range(3));
          it.second_row_offset = 8'($urandom_range(3));
          it.second_col_offset = 8'($urandom_range(3));
        end
      end else begin
        it.op = OP_PIXEL;
        it.pixel_address = 16'(addr);
      end
      send(it);
      pace();
    end
  endtask

  task automatic evaluate(bit [7:0] row, bit [7:0] col);
    in_item_t it;
    prepare_window(row, col);
    it = random_item();
    it.op = OP_EVAL;
    it.window_row = row;
    it.window_col = col;
    send(it);
    pace();
  endtask

  // Half the time revisit a recent window so pixels get reused
  function automatic bit [15:0] next_window();
    bit [15:0] w;
    if (recent_windows.size() != 0 && $urandom_range(1))
      w = recent_windows[$urandom_range(recent_windows.size() - 1)];
    else
      w = 16'($urandom_range(16'hFFFF));
    recent_windows.push_back(w);
    if (recent_windows.size() > 8) void'(recent_windows.pop_front());
    return w;
  endfunction

  task automatic load_node(bit [11:0] slot, bit [7:0] fr, bit [7:0] fc,
                           bit [7:0] sr, bit [7:0] sc);
    in_item_t it;
    it = random_item();
    it.op = OP_NODE;
    it.node_address = slot;
    it.first_row_offset = fr;
    it.first_col_offset = fc;
    it.second_row_offset = sr;
    it.second_col_offset = sc;
    send(it);
  endtask

  task automatic load_pixel(bit [15:0] addr, bit [15:0] value);
    in_item_t it;
    it = random_item();
    it.op = OP_PIXEL;
    it.pixel_address = addr;
    it.pixel_value = value;
    send(it);
  endtask

  // Main sequence
  initial begin
    int phase_end;
    int pick;
    int guard;
    bit last_phase;
    bit [15:0] win;
    bit [8:0] depth_w;
    bit [8:0] count_w;
    bit [8:0] pitch_w;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: ignored opcode, extreme pixels and offsets, ties, both branch directions
    send_op(OP_NONE);
    load_pixel(16'h0000, 16'hFFFF);
    load_pixel(16'hFFFF, 16'h0000);
    load_node(12'hFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    load_node(12'h000, 8'h00, 8'h00, 8'h00, 8'h00);
    evaluate(8'd0, 8'd0);                          // reset register values
    configure(9'd1, 9'd1, 9'd256, 9'd1, 9'd1);
    evaluate(8'd0, 8'd0);                          // tie goes left
    load_node(12'h000, 8'h00, 8'h00, 8'hFF, 8'hFF);
    evaluate(8'd0, 8'd0);                          // larger first pixel goes left
    load_node(12'h000, 8'hFF, 8'hFF, 8'h00, 8'h00);
    evaluate(8'd0, 8'd0);                          // smaller first pixel goes right
    evaluate(8'd255, 8'd255);                      // addresses wrap around the store
    // depth below range saturates up, count above range saturates down; zero pitch
    configure(9'd0, 9'd31, 9'd0, 9'd255, 9'd255);
    evaluate(8'd255, 8'd255);
    evaluate(8'd0, 8'd0);
    // depth above range saturates down; widest pitch, masked stride bits
    configure(9'd15, 9'd1, 9'd511, 9'h100, 9'h1FF);
    evaluate(8'd128, 8'd77);

    // Random phases, each under its own register setting
    for (int phase = 0; phase < PHASES; phase++) begin
      last_phase = (phase == PHASES - 1);
      gaps_on = !last_phase && ($urandom_range(3) != 0);
      depth_w = ($urandom_range(4) == 0) ? 9'($urandom_range(511)) : 9'($urandom_range(1, 4));
      count_w = ($urandom_range(4) == 0) ? 9'($urandom_range(511)) : 9'($urandom_range(1, 4));
      case ($urandom_range(3))
        0: pitch_w = 9'd0;
        1: pitch_w = 9'd511;
        default: pitch_w = 9'($urandom_range(511));
      endcase
      configure(depth_w, count_w, pitch_w, 9'($urandom_range(511)), 9'($urandom_range(511)));
      phase_end = ITEM_TARGET * (phase + 1) / PHASES;
      while (board.items_seen < phase_end ||
             (last_phase && board.leaves_seen + board.leaves_due.size() < 48)) begin
        pick = $urandom_range(99);
        if (pick < 55) begin
          win = next_window();
          evaluate(win[15:8], win[7:0]);
        end else if (pick < 70) begin
          send_op(OP_NODE);
        end else if (pick < 85) begin
          send_op(OP_PIXEL);
        end else if (pick < 93) begin
          send_op(OP_NONE);
        end else if (pick < 96 && !last_phase) begin
          settle();
        end else begin
          evaluate($urandom_range(1) ? 8'd255 : 8'd0, $urandom_range(1) ? 8'd255 : 8'd0);
        end
      end
    end

    // Drain
    start <= 1'b0;
    guard = 0;
    while (board.leaves_due.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (board.leaves_due.size() != 0) begin
      board.errors++;
      $error("%0d leaf results never arrived", board.leaves_due.size());
    end

    $display("Ran %0d load/evaluate transactions (%0d evaluations) under %0d register settings",
             board.items_seen, board.evals_seen, settings_used);
    $display("Checked %0d leaf results with depths 1..8, up to 16 trees, wrapped addressing",
             board.leaves_seen);
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #12_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
